// File: sv/bldc_six_step_commutation_ramp_unit_macros.svh
// Assertion macros for the six-step commutation unit.
// Each macro expects clk and arst_n in scope.
`ifndef BLDC_SIX_STEP_COMMUTATION_RAMP_UNIT_MACROS_SVH
`define BLDC_SIX_STEP_COMMUTATION_RAMP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BLDC6S_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define BLDC6S_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define BLDC6S_ASSERT_IMP(lbl, pre, post)
`define BLDC6S_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: sv/bldc6s_pkg.sv
`timescale 1ns / 1ps
package bldc6s_pkg;

	localparam int CFG_W = 16;
	localparam int DUTY_W = 8;
	localparam int IDX_W = 4;
	localparam int TIME_BITS_DEF = 16;
	localparam int NUM_PHASES = 6;

	localparam logic [CFG_W-1:0] START_ON_RST = 16'd8000;
	localparam logic [CFG_W-1:0] START_OFF_RST = 16'd2400;
	localparam logic [CFG_W-1:0] ON_STEP_RST = 16'd100;
	localparam logic [CFG_W-1:0] OFF_STEP_RST = 16'd30;
	localparam logic [CFG_W-1:0] END_ON_RST = 16'd2000;
	localparam logic [CFG_W-1:0] RUN_ON_RST = 16'd2500;
	localparam logic [CFG_W-1:0] RUN_OFF_RST = 16'd750;
	localparam logic [DUTY_W-1:0] DUTY_RST = 8'd80;

	typedef enum logic [IDX_W-1:0] {
		CFG_START_ON = 4'd0,
		CFG_START_OFF = 4'd1,
		CFG_ON_STEP = 4'd2,
		CFG_OFF_STEP = 4'd3,
		CFG_END_ON = 4'd4,
		CFG_RUN_ON = 4'd5,
		CFG_RUN_OFF = 4'd6,
		CFG_DUTY = 4'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LEG_A = 2'd0,
		LEG_B = 2'd1,
		LEG_C = 2'd2
	} leg_t;

	function automatic leg_t high_leg(input logic [2:0] ph);
		leg_t leg;
		case (ph)
			3'd0: leg = LEG_B;
			3'd1: leg = LEG_C;
			3'd2: leg = LEG_C;
			3'd3: leg = LEG_A;
			3'd4: leg = LEG_A;
			3'd5: leg = LEG_B;
			default: leg = LEG_A;
		endcase
		return leg;
	endfunction

	function automatic leg_t low_leg(input logic [2:0] ph);
		leg_t leg;
		case (ph)
			3'd0, 3'd1: leg = LEG_A;
			3'd2, 3'd3: leg = LEG_B;
			3'd4, 3'd5: leg = LEG_C;
			default: leg = LEG_A;
		endcase
		return leg;
	endfunction

endpackage

// File: sv/bldc_six_step_commutation_ramp_unit.sv
`timescale 1ns / 1ps
// Open-loop six-step BLDC commutation timer with startup ramp.
// Input channel (in_valid/in_stall, payload restart): each word is one
// timer tick; restart=1 reloads the ramp and starts again at phase 0.
// Output channel (out_valid/out_stall): one result word per tick with the
// phase, low- and high-side legs, drive enable, PWM duty and run flag.
// Each result is registered, shown in the cycle after its tick is taken.
// It takes one tick per cycle unless a held result stalls; sequencer state
// and result register both update in the cycle the tick is taken, via one
// subtract-compare-select path on the TIME_BITS interval counter.
// in_stall rises only while a result is held and the receiver stalls it;
// the held result stays unchanged until taken.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write only while idle. Indexes above 7 are ignored.
// Reset loads the register defaults, phase 0, on-time, ramp at its start
// values, and leaves the output register empty.
`include "bldc_six_step_commutation_ramp_unit_macros.svh"
module bldc_six_step_commutation_ramp_unit #(
	parameter int TIME_BITS = bldc6s_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        phase_index,
	output logic [1:0]                        low_switch,
	output logic [1:0]                        high_switch,
	output logic                              drive_enable,
	output logic [bldc6s_pkg::DUTY_W-1:0]     duty_out,
	output logic                              running,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bldc6s_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bldc6s_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CW = bldc6s_pkg::CFG_W;
	localparam logic [31:0] TMAX32 = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
		: ((32'd1 << TIME_BITS) - 32'd1);

	function automatic logic [TIME_BITS-1:0] load_time(input logic [CW-1:0] t);
		logic [31:0] v;
		v = {{(32-CW){1'b0}}, t};
		if (v > TMAX32)
			v = TMAX32;
		return v[TIME_BITS-1:0];
	endfunction

	// configuration registers
	logic [CW-1:0] start_on_q, start_off_q, on_step_q, off_step_q;
	logic [CW-1:0] end_on_q, run_on_q, run_off_q;
	logic [bldc6s_pkg::DUTY_W-1:0] duty_q;

	// sequencer state
	logic                 run_q;
	logic [2:0]           step_q;
	logic                 on_q;
	logic [TIME_BITS-1:0] ticks_q;
	logic [CW-1:0]        ramp_on_q, ramp_off_q;

	logic in_acc;
	logic out_free;

	// state after optional restart
	logic                 run_c, on_c;
	logic [2:0]           ph_c;
	logic [TIME_BITS-1:0] ticks_c;
	logic [CW-1:0]        ramp_on_c, ramp_off_c;

	// next state
	logic                 run_n, on_n;
	logic [2:0]           step_n;
	logic [TIME_BITS-1:0] ticks_n;
	logic [CW-1:0]        ramp_on_n, ramp_off_n;
	logic [CW-1:0]        ramp_on_dec, ramp_off_dec;
	logic                 run_pass;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !out_free;
	assign in_acc = in_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_on_q <= bldc6s_pkg::START_ON_RST;
			start_off_q <= bldc6s_pkg::START_OFF_RST;
			on_step_q <= bldc6s_pkg::ON_STEP_RST;
			off_step_q <= bldc6s_pkg::OFF_STEP_RST;
			end_on_q <= bldc6s_pkg::END_ON_RST;
			run_on_q <= bldc6s_pkg::RUN_ON_RST;
			run_off_q <= bldc6s_pkg::RUN_OFF_RST;
			duty_q <= bldc6s_pkg::DUTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bldc6s_pkg::CFG_START_ON:  start_on_q <= cfg_data;
				bldc6s_pkg::CFG_START_OFF: start_off_q <= cfg_data;
				bldc6s_pkg::CFG_ON_STEP:   on_step_q <= cfg_data;
				bldc6s_pkg::CFG_OFF_STEP:  off_step_q <= cfg_data;
				bldc6s_pkg::CFG_END_ON:    end_on_q <= cfg_data;
				bldc6s_pkg::CFG_RUN_ON:    run_on_q <= cfg_data;
				bldc6s_pkg::CFG_RUN_OFF:   run_off_q <= cfg_data;
				bldc6s_pkg::CFG_DUTY:      duty_q <= cfg_data[bldc6s_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (restart) begin
			ramp_on_c = start_on_q;
			ramp_off_c = start_off_q;
			run_c = !(start_on_q > end_on_q);
			ph_c = 3'd0;
			on_c = 1'b1;
			ticks_c = load_time(run_c ? run_on_q : start_on_q);
		end else begin
			ramp_on_c = ramp_on_q;
			ramp_off_c = ramp_off_q;
			run_c = run_q;
			ph_c = (step_q > 3'd5) ? 3'd0 : step_q;
			on_c = on_q;
			ticks_c = ticks_q;
		end
	end

	always_comb begin
		ramp_on_dec = (ramp_on_c > on_step_q) ? ramp_on_c - on_step_q : '0;
		ramp_off_dec = (ramp_off_c > off_step_q) ? ramp_off_c - off_step_q : '0;
		run_pass = !(ramp_on_dec > end_on_q);
		run_n = run_c;
		on_n = on_c;
		step_n = ph_c;
		ramp_on_n = ramp_on_c;
		ramp_off_n = ramp_off_c;
		if (ticks_c > TIME_BITS'(1)) begin
			ticks_n = ticks_c - TIME_BITS'(1);
		end else if (on_c) begin
			on_n = 1'b0;
			ticks_n = load_time(run_c ? run_off_q : ramp_off_c);
		end else begin
			on_n = 1'b1;
			if (ph_c == 3'd5) begin
				step_n = 3'd0;
				if (!run_c) begin
					ramp_on_n = ramp_on_dec;
					ramp_off_n = ramp_off_dec;
					run_n = run_pass;
				end
			end else begin
				step_n = ph_c + 3'd1;
			end
			ticks_n = load_time(run_n ? run_on_q : ramp_on_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= 3'd0;
			on_q <= 1'b1;
			ticks_q <= load_time(bldc6s_pkg::START_ON_RST);
			ramp_on_q <= bldc6s_pkg::START_ON_RST;
			ramp_off_q <= bldc6s_pkg::START_OFF_RST;
		end else if (in_acc) begin
			run_q <= run_n;
			step_q <= step_n;
			on_q <= on_n;
			ticks_q <= ticks_n;
			ramp_on_q <= ramp_on_n;
			ramp_off_q <= ramp_off_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			phase_index <= ph_c;
			low_switch <= on_c ? bldc6s_pkg::low_leg(ph_c) : bldc6s_pkg::LEG_A;
			high_switch <= on_c ? bldc6s_pkg::high_leg(ph_c) : bldc6s_pkg::LEG_A;
			drive_enable <= on_c;
			duty_out <= on_c ? duty_q : '0;
			running <= run_c;
		end
	end

	`BLDC6S_ASSERT_IMP(a_step_range, 1'b1, step_q <= 3'd5)
	`BLDC6S_ASSERT_IMP(a_off_quiet, out_valid && !drive_enable,
		duty_out == '0 && low_switch == 2'd0 && high_switch == 2'd0)
	`BLDC6S_ASSERT_NXT(a_run_sticky, run_q && !(in_acc && restart), run_q)
	`BLDC6S_ASSERT_NXT(a_hold_state, !in_acc, $stable(step_q) && $stable(ticks_q))

endmodule

// File: tb/commutation_checker.sv
`timescale 1ns / 1ps
module commutation_checker #(
	parameter int TIME_BITS = bldc6s_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [2:0]                        phase_index,
	input  logic [1:0]                        low_switch,
	input  logic [1:0]                        high_switch,
	input  logic                              drive_enable,
	input  logic [bldc6s_pkg::DUTY_W-1:0]     duty_out,
	input  logic                              running,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [bldc6s_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bldc6s_pkg::CFG_W-1:0]      cfg_data,
	output int                                mismatches,
	output int                                waiting,
	output int                                words_checked,
	output int                                running_words
);
	import bldc6s_pkg::*;

	localparam int REG_SLOTS = CFG_DUTY + 1;

	typedef struct packed {
		logic [2:0]        phase;
		leg_t              low_side;
		leg_t              high_side;
		logic              drive;
		logic [DUTY_W-1:0] duty;
		logic              run;
	} tick_word_t;

	tick_word_t        due_words[$];
	logic [CFG_W-1:0]  regs[REG_SLOTS];
	logic              ramp_done;
	logic [2:0]        step;
	logic              driving;
	longint unsigned   ticks_left;
	logic [CFG_W-1:0]  ramp_on;
	logic [CFG_W-1:0]  ramp_off;

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH word %0d: %s got %0d, want %0d", words_checked, what, got, want);
		mismatches++;
	endtask

	function automatic longint unsigned clamp_time(input logic [CFG_W-1:0] t);
		longint unsigned lim;
		lim = (longint'(1) << TIME_BITS) - 1;
		return (t > lim) ? lim : longint'(t);
	endfunction

	function automatic void load_ramp();
		ramp_on = regs[CFG_START_ON];
		ramp_off = regs[CFG_START_OFF];
		step = 3'd0;
		driving = 1'b1;
		ramp_done = !(ramp_on > regs[CFG_END_ON]);
		ticks_left = clamp_time(ramp_done ? regs[CFG_RUN_ON] : ramp_on);
	endfunction

	function automatic tick_word_t predict_tick(input logic reload);
		tick_word_t w;
		if (reload)
			load_ramp();
		if (step > 3'd5)
			step = 3'd0;
		w.phase = step;
		w.drive = driving;
		w.duty = driving ? regs[CFG_DUTY][DUTY_W-1:0] : '0;
		w.run = ramp_done;
		w.low_side = LEG_A;
		w.high_side = LEG_A;
		if (driving) begin
			case (step)
				3'd0, 3'd1: w.low_side = LEG_A;
				3'd2, 3'd3: w.low_side = LEG_B;
				default: w.low_side = LEG_C;
			endcase
			case (step)
				3'd0, 3'd5: w.high_side = LEG_B;
				3'd1, 3'd2: w.high_side = LEG_C;
				default: w.high_side = LEG_A;
			endcase
		end
		if (ticks_left > 1) begin
			ticks_left--;
		end else if (driving) begin
			driving = 1'b0;
			ticks_left = clamp_time(ramp_done ? regs[CFG_RUN_OFF] : ramp_off);
		end else begin
			driving = 1'b1;
			if (step == 3'd5) begin
				step = 3'd0;
				if (!ramp_done) begin
					ramp_on = (ramp_on > regs[CFG_ON_STEP]) ? ramp_on - regs[CFG_ON_STEP] : '0;
					ramp_off = (ramp_off > regs[CFG_OFF_STEP]) ? ramp_off - regs[CFG_OFF_STEP] : '0;
					ramp_done = !(ramp_on > regs[CFG_END_ON]);
				end
			end else begin
				step = step + 3'd1;
			end
			ticks_left = clamp_time(ramp_done ? regs[CFG_RUN_ON] : ramp_on);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tick_word_t w;
		if (!arst_n) begin
			regs[CFG_START_ON] = START_ON_RST;
			regs[CFG_START_OFF] = START_OFF_RST;
			regs[CFG_ON_STEP] = ON_STEP_RST;
			regs[CFG_OFF_STEP] = OFF_STEP_RST;
			regs[CFG_END_ON] = END_ON_RST;
			regs[CFG_RUN_ON] = RUN_ON_RST;
			regs[CFG_RUN_OFF] = RUN_OFF_RST;
			regs[CFG_DUTY] = CFG_W'(DUTY_RST);
			load_ramp();
			due_words.delete();
			waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= CFG_DUTY) begin
				if (cfg_index == CFG_DUTY)
					regs[cfg_index[2:0]] = CFG_W'(cfg_data[DUTY_W-1:0]);
				else
					regs[cfg_index[2:0]] = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					note_mismatch("result word with no tick waiting", 1, 0);
				end else begin
					w = due_words.pop_front();
					if (phase_index !== w.phase)
						note_mismatch("phase_index", phase_index, w.phase);
					if (low_switch !== w.low_side)
						note_mismatch("low_switch", low_switch, w.low_side);
					if (high_switch !== w.high_side)
						note_mismatch("high_switch", high_switch, w.high_side);
					if (drive_enable !== w.drive)
						note_mismatch("drive_enable", drive_enable, w.drive);
					if (duty_out !== w.duty)
						note_mismatch("duty_out", duty_out, w.duty);
					if (running !== w.run)
						note_mismatch("running", running, w.run);
				end
				words_checked++;
				if (running === 1'b1)
					running_words++;
			end
			if (in_valid && !in_stall)
				due_words.push_back(predict_tick(restart));
			waiting <= due_words.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import bldc6s_pkg::*;

	localparam int REG_SLOTS = CFG_DUTY + 1;
	localparam int PHASES = 12;
	localparam int TICKS_PER_PHASE = 100;

	logic                clk;
	logic                arst_n;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                restart = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          phase_index;
	logic [1:0]          low_switch;
	logic [1:0]          high_switch;
	logic                drive_enable;
	logic [DUTY_W-1:0]   duty_out;
	logic                running;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	int mismatches;
	int waiting;
	int words_checked;
	int running_words;
	int settings_used = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	bldc_six_step_commutation_ramp_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase_index(phase_index), .low_switch(low_switch), .high_switch(high_switch),
		.drive_enable(drive_enable), .duty_out(duty_out), .running(running),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	commutation_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase_index(phase_index), .low_switch(low_switch), .high_switch(high_switch),
		.drive_enable(drive_enable), .duty_out(duty_out), .running(running),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .waiting(waiting),
		.words_checked(words_checked), .running_words(running_words)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hold off once for a long stretch so the block fills and stalls its input
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left <= 60;
			hold_taken <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 28);
		end
	end

	task automatic send_tick(input logic reload);
		while (!calm && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			restart <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= reload;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drive_ticks(input int count, input bit fresh);
		for (int i = 0; i < count; i++)
			send_tick((fresh && i == 0) || $urandom_range(0, 79) == 0);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_registers(input logic [CFG_W-1:0] s_on, s_off, on_dec, off_dec,
			end_on, r_on, r_off, input logic [DUTY_W-1:0] duty);
		write_reg(CFG_START_ON, s_on);
		write_reg(CFG_START_OFF, s_off);
		write_reg(CFG_ON_STEP, on_dec);
		write_reg(CFG_OFF_STEP, off_dec);
		write_reg(CFG_END_ON, end_on);
		write_reg(CFG_RUN_ON, r_on);
		write_reg(CFG_RUN_OFF, r_off);
		write_reg(CFG_DUTY, CFG_W'({$urandom_range(0, 255), duty}));
		// unused slot: must be dropped
		write_reg(IDX_W'($urandom_range(REG_SLOTS, (1 << IDX_W) - 1)), CFG_W'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CFG_W-1:0] pick_span(input int base);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return '0;
		if (roll < 9)
			return '1;
		return CFG_W'(base + $urandom_range(1, 6));
	endfunction

	function automatic logic [CFG_W-1:0] pick_step();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		if (roll < 15)
			return '1;
		return CFG_W'($urandom_range(1, 6));
	endfunction

	initial begin : stimulus
		int end_on;
		int n;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		in_valid <= 1'b0;
		wait_drained();

		// zero-length intervals, ramp already done at restart, full duty
		set_registers('0, '0, '0, '0, '0, '0, '0, 8'hFF);
		drive_ticks(13, 1'b1);
		wait_drained();

		// one pass, then both ramp steps underflow and run mode starts
		set_registers(16'd1, '0, '1, '1, '0, 16'd2, 16'd1, 8'h00);
		drive_ticks(14, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			calm <= (p == 5);
			if (p == 3)
				hold_req <= 1'b1;
			if (p == 8) begin
				set_registers('1, '1, '1, '1, '1, '1, '1, 8'hFF);
			end else begin
				end_on = $urandom_range(0, 10);
				set_registers(pick_span(end_on), pick_span(0), pick_step(), pick_step(),
					CFG_W'(end_on), pick_span(0), pick_span(0), DUTY_W'($urandom));
			end
			drive_ticks(TICKS_PER_PHASE, p == 0 || $urandom_range(0, 1) == 1);
		end

		n = 0;
		@(posedge clk);
		while (waiting != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
		if (waiting != 0)
			$display("%0d expected result words never arrived", waiting);
		$display("Covered %0d tick results over %0d register settings, %0d in run mode,",
			words_checked, settings_used, running_words);
		$display("including zero and full-scale times, ramp underflow and a long output stall.");
		if (mismatches == 0 && waiting == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/bldc6s_pkg.sv
sv/bldc_six_step_commutation_ramp_unit.sv
tb/commutation_checker.sv
tb/testbench.sv
